>>> rtl/paged_kv_cache_page_table_defines.svh
// Assertion macros shared by the page table checker.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef PAGED_KV_CACHE_PAGE_TABLE_DEFINES_SVH
`define PAGED_KV_CACHE_PAGE_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PKVC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pkvc_pkg.sv
// Shared types and codes for the paged key/value cache page table.
// No dependencies; imported by every RTL module of the block.
package pkvc_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_FREE   = 2'd2,
    OP_IGNORE = 2'd3
  } pkvc_op_t;

  typedef enum logic [2:0] {
    STAT_HIT     = 3'd0,
    STAT_ALLOC   = 3'd1,
    STAT_RD_MISS = 3'd2,
    STAT_NO_PAGE = 3'd3,
    STAT_FREED   = 3'd4
  } pkvc_status_t;

  typedef enum logic {
    REG_HEADS      = 1'b0,
    REG_HEAD_WIDTH = 1'b1
  } pkvc_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_SUM,
    S_OFS,
    S_SCAN,
    S_OUT
  } pkvc_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  sequence_req;
    logic [15:0] position;
    logic [6:0]  layer;
    logic        val_half;
  } pkvc_in_t;

  typedef struct packed {
    logic [5:0]  page_id;
    logic [27:0] element_offset;
    logic [2:0]  status;
    logic [6:0]  freed_count;
  } pkvc_out_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic valid;
    logic found;
  } pkvc_tok_t;

endpackage

>>> rtl/pkvc_cell.sv
// One page table entry of the scan chain: in-use flag, owner and page number.
// Depends on pkvc_pkg for the opcode and token types.
module pkvc_cell
  import pkvc_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int PNW = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pkvc_tok_t       tok_in,
  input  logic [IW-1:0]   hidx_in,
  input  pkvc_op_t        op,
  input  logic [7:0]      seq,
  input  logic [PNW-1:0]  pnum,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_idx,
  output pkvc_tok_t       tok_out,
  output logic [IW-1:0]   hidx_out,
  output logic            freed
);

  logic           use_r;
  logic [7:0]     own_r;
  logic [PNW-1:0] pn_r;
  pkvc_tok_t      tok_r, tok_nxt;
  logic [IW-1:0]  hidx_r, hidx_nxt;
  logic           freed_r, freed_nxt;
  logic           seq_match, page_match, first_hit, wr_hit;

  assign seq_match  = use_r && (own_r == seq);
  assign page_match = seq_match && (pn_r == pnum);
  assign first_hit  = tok_in.valid && !tok_in.found && (op != OP_FREE) && page_match;
  assign wr_hit     = wr_en && (wr_idx == IW'(IDX));

  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.found = tok_in.found || first_hit;
    hidx_nxt      = first_hit ? IW'(IDX) : hidx_in;
    freed_nxt     = tok_in.valid && (op == OP_FREE) && seq_match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r   <= 1'b0;
      tok_r   <= '0;
      freed_r <= 1'b0;
    end else begin
      tok_r   <= tok_nxt;
      freed_r <= freed_nxt;
      if (wr_hit) begin
        use_r <= 1'b1;
      end else if (freed_nxt) begin
        use_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hidx_r <= hidx_nxt;
    if (wr_hit) begin
      own_r <= seq;
      pn_r  <= pnum;
    end
  end

  assign tok_out  = tok_r;
  assign hidx_out = hidx_r;
  assign freed    = freed_r;

endmodule

>>> rtl/pkvc_free_stack.sv
// Free-page stack with a registered top-of-stack read.
// Entries below the low-water mark were never written and read as their index.
module pkvc_free_stack
  import pkvc_pkg::*;
#(
  parameter  int DEPTH = 64,
  localparam int IW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [IW-1:0] push_idx,
  input  logic          pop,
  output logic [IW-1:0] top,
  output logic          empty
);

  logic [IW-1:0] stk_mem_r [DEPTH];
  logic [CW-1:0] fc_r;
  logic [CW-1:0] lw_r;
  logic [CW-1:0] fc_m1;
  logic [IW-1:0] rd_data_r;
  logic          low_r;

  assign fc_m1 = fc_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= CW'(DEPTH);
      lw_r <= CW'(DEPTH);
    end else if (pop) begin
      fc_r <= fc_m1;
      if (fc_m1 < lw_r) begin
        lw_r <= fc_m1;
      end
    end else if (push && (fc_r < CW'(DEPTH))) begin
      fc_r <= fc_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (fc_r < CW'(DEPTH))) begin
      stk_mem_r[fc_r[IW-1:0]] <= push_idx;
    end
    rd_data_r <= stk_mem_r[fc_m1[IW-1:0]];
    low_r     <= (fc_m1 < lw_r);
  end

  assign top   = low_r ? fc_m1[IW-1:0] : rd_data_r;
  assign empty = (fc_r == '0);

endmodule

>>> rtl/paged_kv_cache_page_table.sv
// Paged key/value cache page table: top level with the scan chain of page cells.
// Depends on pkvc_pkg, pkvc_cell and pkvc_free_stack.
//
// Usage: a request enters on in_valid/in_stall carrying an opcode, a sequence,
// a token position, a layer and the key/value select. Write requests look up
// the page of (sequence, position / PAGE_TOKENS) and allocate one from the free
// stack on a miss; read requests only look up; free requests release every
// page of the sequence in ascending page index. Each request gives one result
// on out_valid/out_stall. Opcode 3 is taken and dropped with no result.
// The configuration port (cfg_we, cfg_index, cfg_data) sets heads and
// head_width; write it only while no request is in flight.
// Flow: after acceptance the block steps through the slot split and the offset
// products in S_DIV, S_MUL, S_SUM and S_OFS, then a token walks the chain of
// MAX_PAGES cells, one cell per cycle, and the result waits in res_r until the
// output register is free. out_valid rises as the result is loaded; only then
// is the next request taken, so the block handles one request at a time.
// Reset empties the table and fills the free stack; no clearing pass is run.
// If the receiver stalls, the finished result waits in the output register
// while the block accepts one more request and holds its result after the scan.
module paged_kv_cache_page_table
  import pkvc_pkg::*;
#(
  parameter int MAX_PAGES   = 64,
  parameter int PAGE_TOKENS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pkvc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pkvc_out_t out_data,
  input  logic      cfg_we,
  input  pkvc_reg_t cfg_index,
  input  logic [8:0] cfg_data
);

  // Widths that follow from the parameters.
  localparam int IW  = $clog2(MAX_PAGES);
  localparam int FCW = $clog2(MAX_PAGES + 1);
  localparam int PNW = $clog2(65535 / PAGE_TOKENS + 1);
  // Reciprocal of PAGE_TOKENS scaled by 2^24; exact for every 16-bit position.
  localparam logic [24:0] RECIP = 25'((2 ** 24 + PAGE_TOKENS - 1) / PAGE_TOKENS);

  pkvc_state_t state_r, state_nxt;
  pkvc_in_t    req_r;
  pkvc_op_t    cur_op;
  logic        acc;
  logic        start_scan;
  logic        scan_on;
  logic        load_out;

  // Configuration registers and their product.
  logic [7:0]  heads_r;
  logic [8:0]  hw_r;
  logic [16:0] s_r;
  logic [16:0] s_prod;

  // Slot split and offset datapath.
  logic [40:0]    recip_prod;
  logic [16:0]    u_prod;
  logic [PNW+8:0] qpt_prod;
  logic [16:0]    t_sum;
  logic [32:0]    off_prod;
  logic [PNW-1:0] q_r;
  logic [15:0]    u_r;
  logic [15:0]    qpt_r;
  logic [15:0]    t_r;
  logic [27:0]    off_r;

  // Scan chain.
  pkvc_tok_t      tok_chain  [MAX_PAGES+1];
  logic [IW-1:0]  hidx_chain [MAX_PAGES+1];
  logic [MAX_PAGES-1:0] freed_vec;
  logic           any_freed;
  logic           done;
  logic           found;
  logic [IW-1:0]  idx_r;
  logic [FCW-1:0] freed_cnt_r;
  logic [FCW-1:0] freed_cnt_nxt;

  // Free stack and allocation.
  logic [IW-1:0]  stk_top;
  logic           stk_empty;
  logic           wr_en;

  // Result staging.
  pkvc_out_t res_r, res_nxt;
  pkvc_out_t out_r;
  logic      out_valid_r;

  assign cur_op = pkvc_op_t'(req_r.opcode);
  assign acc    = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Control: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && (pkvc_op_t'(in_data.opcode) != OP_IGNORE)) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_OFS;
      S_OFS:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control: outputs of the state machine.
  always_comb begin
    in_stall   = 1'b1;
    start_scan = 1'b0;
    scan_on    = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_OFS:  start_scan = 1'b1;
      S_SCAN: scan_on = 1'b1;
      S_OUT:  load_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration. The product of heads and head_width is kept registered in s_r;
  // it settles well before any request uses it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heads_r <= 8'd1;
      hw_r    <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADS:      heads_r <= cfg_data[7:0];
        REG_HEAD_WIDTH: hw_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_prod = 17'(heads_r) * 17'(hw_r);

  always_ff @(posedge clk) begin
    s_r <= s_prod;
  end

  // ---------------------------------------------------------------------------
  // Slot split and offset. The offset is S * (PAGE_TOKENS * (2*layer + val_half)
  // + slot), where S = heads * head_width and slot = position - page * PAGE_TOKENS.
  // The inner term always fits in 16 bits; the product wraps to 28 bits.
  // ---------------------------------------------------------------------------
  assign recip_prod = 41'(req_r.position) * 41'(RECIP);
  assign u_prod     = 17'({req_r.layer, req_r.val_half}) * 17'(PAGE_TOKENS);
  assign qpt_prod   = (PNW + 9)'(q_r) * (PNW + 9)'(PAGE_TOKENS);
  assign t_sum      = 17'(u_r) + 17'(req_r.position) - 17'(qpt_r);
  assign off_prod   = 33'(s_r) * 33'(t_r);

  always_ff @(posedge clk) begin
    if (acc) begin
      req_r <= in_data;
    end
    if (state_r == S_DIV) begin
      q_r <= recip_prod[24 +: PNW];
      u_r <= u_prod[15:0];
    end
    if (state_r == S_MUL) begin
      qpt_r <= qpt_prod[15:0];
    end
    if (state_r == S_SUM) begin
      t_r <= t_sum[15:0];
    end
    if (state_r == S_OFS) begin
      off_r <= off_prod[27:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Scan chain. A token enters cell 0 in S_OFS, as the offset is registered,
  // and moves one cell per cycle. Each cell checks itself against the request;
  // the first matching cell stamps its index into the token, so the lowest
  // index wins. On a free request each matching cell clears itself and raises
  // a strobe; since only one cell holds the token at a time, at most one strobe
  // is high, and idx_r names the cell that raised it.
  // ---------------------------------------------------------------------------
  assign tok_chain[0].valid = start_scan;
  assign tok_chain[0].found = 1'b0;
  assign hidx_chain[0]      = '0;

  for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
    pkvc_cell #(
      .IDX (g),
      .IW  (IW),
      .PNW (PNW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok_chain[g]),
      .hidx_in  (hidx_chain[g]),
      .op       (cur_op),
      .seq      (req_r.sequence_req),
      .pnum     (q_r),
      .wr_en    (wr_en),
      .wr_idx   (stk_top),
      .tok_out  (tok_chain[g+1]),
      .hidx_out (hidx_chain[g+1]),
      .freed    (freed_vec[g])
    );
  end

  assign any_freed     = |freed_vec;
  assign done          = tok_chain[MAX_PAGES].valid;
  assign found         = tok_chain[MAX_PAGES].found;
  assign freed_cnt_nxt = freed_cnt_r + FCW'(any_freed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      freed_cnt_r <= '0;
    end else if (start_scan) begin
      idx_r       <= '0;
      freed_cnt_r <= '0;
    end else if (scan_on) begin
      idx_r       <= idx_r + IW'(1);
      freed_cnt_r <= freed_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Free stack. Freed pages are pushed as the token passes them; on a write
  // miss the top page is popped and written into its cell when the scan ends.
  // ---------------------------------------------------------------------------
  assign wr_en = done && (cur_op == OP_WRITE) && !found && !stk_empty;

  pkvc_free_stack #(
    .DEPTH (MAX_PAGES)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (scan_on && any_freed),
    .push_idx (idx_r),
    .pop      (wr_en),
    .top      (stk_top),
    .empty    (stk_empty)
  );

  // ---------------------------------------------------------------------------
  // Result. Built when the token leaves the last cell, held in res_r and moved
  // into the output register once that register is free.
  // ---------------------------------------------------------------------------
  always_comb begin
    res_nxt = '0;
    if (cur_op == OP_FREE) begin
      res_nxt.status      = STAT_FREED;
      res_nxt.freed_count = 7'(freed_cnt_nxt);
    end else if (found) begin
      res_nxt.status         = STAT_HIT;
      res_nxt.page_id        = 6'(hidx_chain[MAX_PAGES]);
      res_nxt.element_offset = off_r;
    end else if (cur_op == OP_READ) begin
      res_nxt.status = STAT_RD_MISS;
    end else if (stk_empty) begin
      res_nxt.status = STAT_NO_PAGE;
    end else begin
      res_nxt.status         = STAT_ALLOC;
      res_nxt.page_id        = 6'(stk_top);
      res_nxt.element_offset = off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_on && done) begin
      res_r <= res_nxt;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/pkvc_checker.sv
// Port-level checks for the page table, bound to the top level below.
// Depends on pkvc_pkg and the assertion macros in the defines header.
`include "paged_kv_cache_page_table_defines.svh"

module pkvc_checker
  import pkvc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input pkvc_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input pkvc_out_t out_data
);

  `PKVC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  `PKVC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall && (in_data.opcode != OP_IGNORE), in_stall, "new request taken while one is in flight")

  `PKVC_ASSERT_SAME(a_offset_zero, out_valid && (out_data.status != STAT_HIT) && (out_data.status != STAT_ALLOC), (out_data.element_offset == '0) && (out_data.page_id == '0), "miss or free result carries a page or offset")

  `PKVC_ASSERT_SAME(a_freed_only_on_free, out_valid && (out_data.status != STAT_FREED), out_data.freed_count == '0, "freed count on a non-free result")

endmodule

bind paged_kv_cache_page_table pkvc_checker u_pkvc_checker (.*);

>>> tb/tb_paged_kv_cache_page_table.sv
// Self-checking testbench for the paged key/value cache page table.
// Depends on pkvc_pkg and the paged_kv_cache_page_table RTL; drives random
// and directed requests and checks each result against an in-bench predictor.
module tb_paged_kv_cache_page_table;
  timeunit 1ns;
  timeprecision 1ps;

  import pkvc_pkg::*;

  localparam int PAGES       = 64;
  localparam int PAGE_TOKENS = 16;
  // A request walks the slot split and then the chain of PAGES cells before
  // its result appears; opcode 3 is taken and dropped silently, so after the
  // last result we still wait out SETTLE_CYCLES, longer than that walk.
  localparam int SETTLE_CYCLES = PAGES + 16;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The worst honest gap adds up a sender gap, the block's own work on a
  // request, a receiver hold and an idle pause before a register write, so
  // this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int TOTAL_REQUESTS = 950;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  pkvc_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  pkvc_out_t  out_data;
  logic       cfg_we;
  pkvc_reg_t  cfg_index;
  logic [8:0] cfg_data;

  paged_kv_cache_page_table #(
    .MAX_PAGES  (PAGES),
    .PAGE_TOKENS(PAGE_TOKENS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Page table mirror. This is our own copy of the block's state: which pages
  // are in use, who owns them, which page number each one holds, and the
  // stack of spare page ids with its fill level.
  // ---------------------------------------------------------------------------
  logic        pg_busy   [PAGES];
  logic [7:0]  pg_seq    [PAGES];
  logic [11:0] pg_num    [PAGES];
  logic [5:0]  spare_pages[PAGES];
  int          spare_cnt;
  logic [7:0]  cur_heads;
  logic [8:0]  cur_width;

  // Expected results in request order, plus bookkeeping for the checker.
  pkvc_out_t   pending_results[$];
  int          mismatches;
  int          quiet_cycles;

  // A directed row may carry a result typed in by hand; the driver presents
  // it beside the request so the checker can take it on acceptance.
  logic        pin_valid;
  pkvc_out_t   pin_result;

  // Sequence ids that the random part keeps coming back to, so that lookups
  // hit, tables fill up and frees actually release pages.
  logic [7:0]  seq_pool[6];

  typedef struct {
    pkvc_in_t  req;
    bit        pinned;
    pkvc_out_t res;
  } probe_row_t;

  probe_row_t directed_rows[$];

  function automatic void clear_page_table();
    for (int i = 0; i < PAGES; i++) begin
      pg_busy[i]     = 1'b0;
      pg_seq[i]      = '0;
      pg_num[i]      = '0;
      spare_pages[i] = 6'(i);
    end
    spare_cnt = PAGES;
    cur_heads = 8'd1;
    cur_width = 9'd1;
  endfunction

  // Element offset of a token slot: layers are laid out as a key half and a
  // value half of PAGE_TOKENS slots each, every slot heads*head_width wide.
  // The sum is formed at full width and then cut to the 28 bit field.
  function automatic logic [27:0] slot_offset(logic [6:0] layer, logic val_half,
                                              logic [3:0] slot);
    longint unsigned stride;
    longint unsigned half;
    longint unsigned total;
    stride = longint'(cur_heads) * longint'(cur_width);
    half   = PAGE_TOKENS * stride;
    total  = longint'(layer) * 2 * half + (val_half ? half : 0) + longint'(slot) * stride;
    return total[27:0];
  endfunction

  // Applies one accepted request to the mirror and works out its result.
  // Opcode 3 leaves everything alone and produces nothing.
  function automatic void predict_request(input pkvc_in_t r, output bit has_res,
                                          output pkvc_out_t res);
    logic [11:0] pnum;
    logic [3:0]  slot;
    int          hit;
    int          freed;
    logic [5:0]  p;
    res     = '0;
    has_res = 1'b1;
    pnum    = 12'(r.position / PAGE_TOKENS);
    slot    = 4'(r.position % PAGE_TOKENS);
    case (pkvc_op_t'(r.opcode))
      OP_IGNORE: begin
        has_res = 1'b0;
      end
      OP_FREE: begin
        // Release in ascending page index; each released page goes on top of
        // the spare stack, so the highest one freed is the next handed out.
        freed = 0;
        for (int i = 0; i < PAGES; i++) begin
          if (pg_busy[i] && pg_seq[i] == r.sequence_req) begin
            pg_busy[i] = 1'b0;
            pg_seq[i]  = '0;
            pg_num[i]  = '0;
            if (spare_cnt < PAGES) begin
              spare_pages[spare_cnt] = 6'(i);
              spare_cnt++;
            end
            freed++;
          end
        end
        res.status      = STAT_FREED;
        res.freed_count = 7'(freed);
      end
      default: begin
        // Lowest matching page index wins.
        hit = -1;
        for (int i = 0; i < PAGES; i++) begin
          if (hit < 0 && pg_busy[i] && pg_seq[i] == r.sequence_req && pg_num[i] == pnum)
            hit = i;
        end
        if (hit >= 0) begin
          res.page_id        = 6'(hit);
          res.element_offset = slot_offset(r.layer, r.val_half, slot);
          res.status         = STAT_HIT;
        end else if (r.opcode == OP_READ) begin
          res.status = STAT_RD_MISS;
        end else if (spare_cnt == 0) begin
          res.status = STAT_NO_PAGE;
        end else begin
          spare_cnt--;
          p          = spare_pages[spare_cnt];
          pg_busy[p] = 1'b1;
          pg_seq[p]  = r.sequence_req;
          pg_num[p]  = pnum;
          res.page_id        = p;
          res.element_offset = slot_offset(r.layer, r.val_half, slot);
          res.status         = STAT_ALLOC;
        end
      end
    endcase
  endfunction

  task automatic flag_result(string what, pkvc_out_t want, pkvc_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected page %0d offset %0d status %0d freed %0d, %s",
               $realtime, what, want.page_id, want.element_offset, want.status,
               want.freed_count,
               $sformatf("got page %0d offset %0d status %0d freed %0d",
                         got.page_id, got.element_offset, got.status,
                         got.freed_count));
  endtask

  // ---------------------------------------------------------------------------
  // Checker. Everything is sampled at the rising edge: register writes update
  // the mirror's configuration, accepted requests are predicted, and accepted
  // results are compared against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    bit        has_res;
    pkvc_out_t res;
    pkvc_out_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_HEADS:      cur_heads = cfg_data[7:0];
        REG_HEAD_WIDTH: cur_width = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && in_valid && !in_stall) begin
      moved = 1'b1;
      predict_request(in_data, has_res, res);
      if (has_res)
        pending_results.push_back(pin_valid ? pin_result : res);
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (pending_results.size() == 0) begin
        flag_result("result with no request pending", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.page_id        !== want.page_id        ||
            out_data.element_offset !== want.element_offset ||
            out_data.status         !== want.status         ||
            out_data.freed_count    !== want.freed_count)
          flag_result("result mismatch", want, out_data);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("[paged_kv_cache_page_table] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side. The receiver runs through modes of its own: no stalls at all,
  // light and heavy random stalls, and rare long holds that back the block up
  // so a second request has to wait behind a finished result.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int mode;
    int span;
    int hold;
    out_stall = 1'b0;
    hold      = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(negedge clk);
        if (hold > 0) begin
          hold--;
          out_stall = 1'b1;
        end else begin
          case (mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 9) < 3);
            2: out_stall = ($urandom_range(0, 9) < 7);
            default: begin
              if ($urandom_range(0, 49) == 0)
                hold = $urandom_range(1, 150);
              out_stall = (hold > 0);
            end
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers. Inputs change only at the falling edge; a request
  // counts as taken at the first rising edge where the block is not stalling.
  // ---------------------------------------------------------------------------
  task automatic send_request(pkvc_in_t req, bit pinned, pkvc_out_t res);
    @(negedge clk);
    in_valid   = 1'b1;
    in_data    = req;
    pin_valid  = pinned;
    pin_result = res;
    do
      @(posedge clk);
    while (in_stall);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid  = 1'b0;
    pin_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Registers are only touched when nothing is in flight; an opcode 3
  // request is dropped on acceptance and never walks the chain.
  task automatic settle_block();
    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pkvc_reg_t idx, logic [8:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic void add_row(pkvc_op_t op, int seq, int pos, int layer, bit val_half,
                                  bit pinned = 1'b0, int pid = 0, int ofs = 0,
                                  pkvc_status_t st = STAT_HIT, int freed = 0);
    probe_row_t row;
    row.req.opcode             = op;
    row.req.sequence_req       = 8'(seq);
    row.req.position           = 16'(pos);
    row.req.layer              = 7'(layer);
    row.req.val_half           = val_half;
    row.pinned                 = pinned;
    row.res.page_id            = 6'(pid);
    row.res.element_offset     = 28'(ofs);
    row.res.status             = st;
    row.res.freed_count        = 7'(freed);
    directed_rows.push_back(row);
  endfunction

  // Random request shaped around the current sequence pool and a window of
  // page numbers starting at page_base, so most traffic hits, allocates and
  // fills the table; about one in five sequences and positions is drawn from the whole range.
  function automatic pkvc_in_t make_request(int free_pct, int page_span,
                                            logic [11:0] page_base);
    pkvc_in_t r;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      r.opcode = OP_IGNORE;
    else if (roll < 3 + free_pct)
      r.opcode = OP_FREE;
    else if (roll < 60)
      r.opcode = OP_WRITE;
    else
      r.opcode = OP_READ;
    if ($urandom_range(0, 9) < 8)
      r.sequence_req = seq_pool[$urandom_range(0, 5)];
    else
      r.sequence_req = 8'($urandom);
    // With 16 tokens per page the position is the page number over the slot.
    if ($urandom_range(0, 9) < 8)
      r.position = {12'(page_base + $urandom_range(0, page_span - 1)), 4'($urandom)};
    else
      r.position = 16'($urandom);
    r.layer    = 7'($urandom);
    r.val_half = 1'($urandom);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main stimulus: reset, a short directed pass under the reset configuration,
  // then random phases, each under its own heads/head_width setting.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    pkvc_in_t    req;
    int          counted;
    int          phase_goal;
    int          burst_left;
    int          free_pct;
    int          page_span;
    logic [11:0] page_base;
    bit          gaps_on;
    logic [8:0]  h;
    logic [8:0]  w;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_HEADS;
    cfg_data   = '0;
    pin_valid  = 1'b0;
    pin_result = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    clear_page_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass. With heads = head_width = 1 an offset is simply
    // layer*32 + val_half*16 + slot, so hand-typed results are easy to read.
    // A fresh stack hands out page 63 first, then 62, and so on downward.
    add_row(OP_READ,  0,   0,     0,     0, 1, 0,  0,    STAT_RD_MISS);
    add_row(OP_WRITE, 0,   0,     0,     0, 1, 63, 0,    STAT_ALLOC);
    add_row(OP_WRITE, 0,   15,    0,     0, 1, 63, 15,   STAT_HIT);
    add_row(OP_READ,  0,   15,    127,   1, 1, 63, 4095, STAT_HIT);
    // The unused opcode must leave the table alone, so the read after it
    // still misses on page number 1.
    add_row(OP_IGNORE, 0,  16,    0,     0);
    add_row(OP_READ,  0,   16,    0,     0, 1, 0,  0,    STAT_RD_MISS);
    // Freeing a sequence that owns nothing still answers, with zero pages.
    add_row(OP_FREE,  200, 0,     0,     0, 1, 0,  0,    STAT_FREED, 0);
    add_row(OP_WRITE, 255, 65535, 127,   1, 1, 62, 4095, STAT_ALLOC);
    add_row(OP_WRITE, 255, 65520, 0,     0, 1, 62, 0,    STAT_HIT);
    add_row(OP_WRITE, 255, 0,     3,     0);
    add_row(OP_WRITE, 1,   0,     0,     1);
    add_row(OP_READ,  255, 'hAAAA, 'h2A, 1);
    add_row(OP_WRITE, 0,   'h5555, 'h55, 1);
    add_row(OP_FREE,  255, 0,     0,     0, 1, 0,  0,    STAT_FREED, 2);
    add_row(OP_WRITE, 7,   32,    1,     0);
    add_row(OP_READ,  255, 65535, 0,     0, 1, 0,  0,    STAT_RD_MISS);
    add_row(OP_FREE,  0,   0,     0,     0);
    add_row(OP_FREE,  0,   0,     0,     0, 1, 0,  0,    STAT_FREED, 0);
    add_row(OP_READ,  1,   5,     100,   1);
    add_row(OP_FREE,  1,   'hFFFF, 'h7F, 1);
    add_row(OP_FREE,  7,   0,     0,     0);
    add_row(OP_IGNORE, 255, 65535, 127,  1);

    counted = 0;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].res);
      if (directed_rows[i].req.opcode != OP_IGNORE)
        counted++;
    end

    // Random phases. Each one starts from an idle block with a new register
    // setting: both extremes of the legal range, zero in either register,
    // an all-ones setting whose offsets overflow 28 bits, and random values.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin h = 9'd128; w = 9'd256; end
        1: begin h = 9'd1;   w = 9'd1;   end
        2: begin h = 9'd255; w = 9'd511; end
        3: begin h = 9'd0;   w = 9'($urandom_range(1, 256)); end
        4: begin h = 9'($urandom_range(1, 128)); w = 9'd0; end
        default: begin
          h = 9'($urandom_range(1, 128));
          w = 9'($urandom_range(1, 256));
        end
      endcase
      settle_block();
      write_reg(REG_HEADS, h);
      write_reg(REG_HEAD_WIDTH, w);

      // Some phases almost never free, so the table runs out of pages;
      // others free often enough to recycle pages through the stack.
      free_pct  = (phase % 3 == 0) ? 1 : 7;
      page_span = (phase % 2 == 0) ? 32 : 12;
      page_base = 12'($urandom);
      foreach (seq_pool[k])
        seq_pool[k] = 8'($urandom);
      seq_pool[0] = (phase % 2 == 0) ? 8'd0 : 8'd255;
      gaps_on     = (phase != 1);
      burst_left  = $urandom_range(1, 30);
      phase_goal  = counted + (TOTAL_REQUESTS - counted) / (RANDOM_PHASES - phase);

      while (counted < phase_goal) begin
        if (gaps_on && burst_left <= 0) begin
          drop_valid();
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 90)) @(posedge clk);
          else
            repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = $urandom_range(1, 30);
        end
        // Now and then hold back entirely until every result is home.
        if ($urandom_range(0, 80) == 0) begin
          drop_valid();
          wait_drained();
        end
        req = make_request(free_pct, page_span, page_base);
        send_request(req, 1'b0, '0);
        if (req.opcode != OP_IGNORE)
          counted++;
        burst_left--;
      end
    end

    settle_block();
    if (mismatches == 0)
      $display("[paged_kv_cache_page_table] OK");
    else
      $display("[paged_kv_cache_page_table] ERROR");
    $finish;
  end

endmodule
